// ===== src/ordered_issue_queue_with_squash_macros.svh =====
// Assertion macros for the ordered issue queue checker.
// Used by oiq_checker; needs nothing else.
`ifndef ORDERED_ISSUE_QUEUE_WITH_SQUASH_MACROS_SVH
`define ORDERED_ISSUE_QUEUE_WITH_SQUASH_MACROS_SVH

// Plain property under reset.
`define OIQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication under reset.
`define OIQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/oiq_pkg.sv =====
// Shared types and constants for the ordered issue queue.
// No dependencies.
`timescale 1ns / 1ps

package oiq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W       = 5;

    localparam logic [1:0] FUNC_ENQ    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_SQUASH = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] instr_addr;
        logic [3:0]  tag;
    } cmd_t;

    typedef struct packed {
        logic             done_res;
        logic [OUT_W-1:0] removed;
        logic [OUT_W-1:0] occupancy;
        logic             is_full;
        logic             is_empty;
    } result_t;

    typedef struct packed {
        logic [15:0] instr_addr;
        logic [3:0]  tag;
    } entry_t;

    typedef struct packed {
        logic        shift;
        logic        by_addr;
        logic [15:0] key_addr;
        logic [3:0]  key_tag;
    } cell_ctl_t;

endpackage

// ===== src/oiq_cell.sv =====
// One queue slot: holds an entry, compares it against the key and collapses
// from its upper neighbour once a deletion lies at or below it. Uses oiq_pkg.
`timescale 1ns / 1ps

module oiq_cell
(
    input  logic               clk,
    input  oiq_pkg::cell_ctl_t ctl,
    input  logic               live,
    input  logic               wr,
    input  oiq_pkg::entry_t    wdata,
    input  logic               hit_in,
    input  oiq_pkg::entry_t    up_entry,
    output logic               hit_out,
    output oiq_pkg::entry_t    entry
);

    oiq_pkg::entry_t entry_reg;
    oiq_pkg::entry_t entry_next;
    logic            match;

    always_comb
    begin
        if (ctl.by_addr)
        begin
            match = live && (entry_reg.instr_addr == ctl.key_addr);
        end
        else
        begin
            match = live && (entry_reg.tag == ctl.key_tag);
        end
    end

    // first hit only: the chain carries "deleted at or below"
    assign hit_out = hit_in || match;

    always_comb
    begin
        priority if (wr)
        begin
            entry_next = wdata;
        end
        else if (ctl.shift && hit_out)
        begin
            entry_next = up_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== src/ordered_issue_queue_with_squash.sv =====
// Top level of the ordered issue queue: control, counters and the cell row.
// Uses oiq_pkg and oiq_cell.
`timescale 1ns / 1ps

// Command port: a command is taken when start is high and busy is low. Its
// result is registered onto result, marked by done for exactly one cycle;
// there is no back-pressure, so capture it then. Enqueue, remove and
// unknown codes never raise busy. Squash collapses one matching entry per
// cycle through the cell row and holds busy meanwhile, until no entry matches.
module ordered_issue_queue_with_squash
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  oiq_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output oiq_pkg::result_t result
);

    typedef enum logic
    {
        ST_IDLE,
        ST_SQUASH
    } state_t;

    localparam int D = oiq_pkg::QUEUE_DEPTH;
    localparam int W = oiq_pkg::CNT_W;

    state_t                 state_reg, state_next;
    logic [W-1:0]           count_reg, count_next;
    logic [W-1:0]           rcnt_reg, rcnt_next;
    logic [3:0]             key_reg, key_next;
    logic                   done_reg, done_next;
    oiq_pkg::result_t       result_reg, result_next;

    oiq_pkg::cell_ctl_t     ctl;
    oiq_pkg::entry_t        wdata;
    oiq_pkg::entry_t        cell_entry [D];
    logic [D:0]             hit;
    logic                   any_hit;
    logic                   enq_go;
    logic                   emit_ok;
    logic [W-1:0]           emit_rm;

    assign wdata.instr_addr = cmd.instr_addr;
    assign wdata.tag        = cmd.tag;
    assign hit[0]           = 1'b0;
    assign any_hit          = hit[D];

    for (genvar i = 0; i < D; i++)
    begin : g_cell
        logic            live;
        logic            wr;
        oiq_pkg::entry_t up;

        assign live = (W'(i) < count_reg);
        assign wr   = enq_go && (count_reg == W'(i));

        if (i == D - 1)
        begin : g_last
            assign up = cell_entry[i];
        end
        else
        begin : g_mid
            assign up = cell_entry[i+1];
        end

        oiq_cell u_cell
        (
            .clk      (clk),
            .ctl      (ctl),
            .live     (live),
            .wr       (wr),
            .wdata    (wdata),
            .hit_in   (hit[i]),
            .up_entry (up),
            .hit_out  (hit[i+1]),
            .entry    (cell_entry[i])
        );
    end

    always_comb
    begin
        ctl.shift    = 1'b0;
        ctl.by_addr  = 1'b0;
        ctl.key_addr = cmd.instr_addr;
        ctl.key_tag  = cmd.tag;
        enq_go       = 1'b0;
        emit_ok      = 1'b0;
        emit_rm      = '0;
        state_next   = state_reg;
        count_next   = count_reg;
        rcnt_next    = rcnt_reg;
        key_next     = key_reg;
        done_next    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    unique case (cmd.func)
                        oiq_pkg::FUNC_ENQ:
                        begin
                            enq_go  = (count_reg < W'(D));
                            emit_ok = enq_go;
                            if (enq_go)
                            begin
                                count_next = count_reg + W'(1);
                            end
                        end
                        oiq_pkg::FUNC_REMOVE:
                        begin
                            ctl.shift   = 1'b1;
                            ctl.by_addr = 1'b1;
                            emit_ok     = any_hit;
                            emit_rm     = W'(any_hit);
                            if (any_hit)
                            begin
                                count_next = count_reg - W'(1);
                            end
                        end
                        oiq_pkg::FUNC_SQUASH:
                        begin
                            ctl.shift = 1'b1;
                            key_next  = cmd.tag;
                            if (any_hit)
                            begin
                                count_next = count_reg - W'(1);
                                rcnt_next  = W'(1);
                                state_next = ST_SQUASH;
                                done_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            emit_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_SQUASH:
            begin
                ctl.shift   = 1'b1;
                ctl.key_tag = key_reg;
                if (any_hit)
                begin
                    count_next = count_reg - W'(1);
                    rcnt_next  = rcnt_reg + W'(1);
                end
                else
                begin
                    done_next  = 1'b1;
                    emit_ok    = 1'b1;
                    emit_rm    = rcnt_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        result_next.done_res  = emit_ok;
        result_next.removed   = oiq_pkg::OUT_W'(emit_rm);
        result_next.occupancy = oiq_pkg::OUT_W'(count_next);
        result_next.is_full   = (count_next == W'(D));
        result_next.is_empty  = (count_next == '0);
        if (!done_next)
        begin
            result_next = result_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rcnt_reg   <= '0;
            key_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rcnt_reg   <= rcnt_next;
            key_reg    <= key_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg == ST_SQUASH);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/oiq_checker.sv =====
// Port-level checks for the ordered issue queue, bound to the top level.
// Uses oiq_pkg and ordered_issue_queue_with_squash_macros.svh.
`timescale 1ns / 1ps
`include "ordered_issue_queue_with_squash_macros.svh"

module oiq_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input oiq_pkg::cmd_t    cmd,
    input logic             busy,
    input logic             done,
    input oiq_pkg::result_t result
);

    `OIQ_ASSERT_IMP(a_done_not_busy, clk, rst_n, done, !busy, "result beat while busy")
    `OIQ_ASSERT_IMP(a_fast_cmd, clk, rst_n, start && !busy && cmd.func != oiq_pkg::FUNC_SQUASH, ##1 done, "single-cycle command gave no result beat")
    `OIQ_ASSERT_IMP(a_busy_end, clk, rst_n, $fell(busy), done, "squash ended without a result beat")
    `OIQ_ASSERT_IMP(a_removed_done, clk, rst_n, done && result.removed != '0, result.done_res, "entries removed but done_res low")
    `OIQ_ASSERT(a_flags, clk, rst_n, !(done && result.is_full && result.is_empty), "full and empty together")

endmodule

bind ordered_issue_queue_with_squash oiq_checker u_oiq_checker (.*);
